/* rtl/core/three_circle_grid_collision_check_core_assert.svh */
// assertion macros for the three-circle collision check core
// used by the port-level checker; no other dependencies
`ifndef THREE_CIRCLE_GRID_COLLISION_CHECK_CORE_ASSERT_SVH
`define THREE_CIRCLE_GRID_COLLISION_CHECK_CORE_ASSERT_SVH

// antecedent in this cycle, consequent in the next, masked while in reset
`define TCGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// antecedent and consequent in the same cycle, masked while in reset
`define TCGC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check that also runs during reset
`define TCGC_ASSERT_NEXT_NORST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tcgc_pkg.sv */
// shared constants, types, trig table and microprogram for the collision check core
// no dependencies
`timescale 1ns / 1ps

package tcgc_pkg;

    // grid and heading geometry
    localparam int MAX_MAP_WIDTH  = 256;
    localparam int MAX_MAP_HEIGHT = 256;
    localparam int HEADING_STEPS  = 4096;
    localparam int MAP_DEPTH      = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
    localparam int MAP_ADDR_BITS  = $clog2(MAP_DEPTH);
    localparam int HEADING_BITS   = $clog2(HEADING_STEPS);
    localparam int QUARTER_BITS   = HEADING_BITS - 2;
    localparam int QUARTER_STEPS  = HEADING_STEPS / 4;

    // field widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int SIZE_W      = 9;
    localparam int OFFSET_W    = 8;
    localparam int CELL_FIELD_W = 8;
    localparam int POSE_W      = 21;
    localparam int HEADING_W   = 12;
    localparam int MASK_W      = 3;

    // stream packing
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_FIELD_W = 1 + MASK_W;
    localparam int COL_LSB     = 0;
    localparam int ROW_LSB     = 8;
    localparam int BYTE_LSB    = 16;
    localparam int PX_LSB      = 24;
    localparam int PY_LSB      = 45;
    localparam int HEAD_LSB    = 66;

    // fixed-point datapath
    localparam int FRAC_BITS = 14;
    localparam int POS_W     = POSE_W + 6;          // pose * 64
    localparam int DX_W      = 24;                  // offset * trig
    localparam int COORD_W   = POS_W + 1;
    localparam int CELL_W    = COORD_W - FRAC_BITS;
    localparam int TRIG_W    = 15;                  // unsigned q1.14 magnitude
    localparam int TRIG_S_W  = 16;

    localparam logic [CELL_FIELD_W-1:0] OCCUPIED_BYTE = 8'd100;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CIRCLE_OFFSET = 2'd2;

    localparam logic [SIZE_W-1:0]   MAP_WIDTH_RST     = 9'd256;
    localparam logic [SIZE_W-1:0]   MAP_HEIGHT_RST    = 9'd256;
    localparam logic [OFFSET_W-1:0] CIRCLE_OFFSET_RST = 8'd1;

    // mode flag on the input tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // taylor constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint      ONE_Q30     = longint'(1) << 30;

    // quarter-wave table: {sin, cos} in q1.14 for the first quadrant
    typedef logic [QUARTER_STEPS-1:0][2*TRIG_W-1:0] t_trig_rom;

    function automatic logic [TRIG_W-1:0] q30_to_q14(input longint v);
        longint cl;
        cl = v;
        if (cl < 0) cl = 0;
        if (cl > ONE_Q30) cl = ONE_Q30;
        return TRIG_W'((cl + 32768) >>> 16);
    endfunction

    function automatic logic [2*TRIG_W-1:0] trig_entry(input int k);
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] t;
        longint      s;
        longint      c;
        p = (64'(k) << 32) / 64'(HEADING_STEPS);
        r = p & 64'h3FFF_FFFF;
        x = (r * HALF_PI_Q30) >> 30;
        s = 0;
        t = x;
        for (int i = 0; i < 8; i++) begin
            s = ((i & 1) != 0) ? s - longint'(t) : s + longint'(t);
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * i + 2) * (2 * i + 3));
        end
        c = 0;
        t = 64'(ONE_Q30);
        for (int i = 0; i < 9; i++) begin
            c = ((i & 1) != 0) ? c - longint'(t) : c + longint'(t);
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * i + 1) * (2 * i + 2));
        end
        return {q30_to_q14(s), q30_to_q14(c)};
    endfunction

    function automatic t_trig_rom build_trig_rom();
        t_trig_rom rom;
        for (int k = 0; k < QUARTER_STEPS; k++) begin
            rom[k] = trig_entry(k);
        end
        return rom;
    endfunction

    localparam t_trig_rom TRIG_ROM = build_trig_rom();

    // microprogram
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_PROBE_C = 3'd1;
    localparam logic [STEP_W-1:0] STEP_EVAL_C  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PROBE_F = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EVAL_F  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EVAL_R  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_DONE    = 3'd6;

    localparam logic [1:0] SEL_CENTRE = 2'd0;
    localparam logic [1:0] SEL_FRONT  = 2'd1;
    localparam logic [1:0] SEL_REAR   = 2'd2;

    typedef struct packed {
        logic              trig_load;
        logic              probe_en;
        logic [1:0]        probe_sel;
        logic              eval_en;
        logic              mult_en;
        logic              done;
        logic [STEP_W-1:0] next;
    } t_uword;

    // control store: one word per step, hit during an eval jumps to STEP_DONE
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            STEP_PROBE_C: begin
                w.trig_load = 1'b1;
                w.probe_en  = 1'b1;
                w.probe_sel = SEL_CENTRE;
                w.next      = STEP_EVAL_C;
            end
            STEP_EVAL_C: begin
                w.eval_en = 1'b1;
                w.mult_en = 1'b1;
                w.next    = STEP_PROBE_F;
            end
            STEP_PROBE_F: begin
                w.probe_en  = 1'b1;
                w.probe_sel = SEL_FRONT;
                w.next      = STEP_EVAL_F;
            end
            STEP_EVAL_F: begin
                w.eval_en   = 1'b1;
                w.probe_en  = 1'b1;
                w.probe_sel = SEL_REAR;
                w.next      = STEP_EVAL_R;
            end
            STEP_EVAL_R: begin
                w.eval_en = 1'b1;
                w.next    = STEP_DONE;
            end
            STEP_DONE: begin
                w.done = 1'b1;
                w.next = STEP_IDLE;
            end
            default: begin
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/tcgc_ram.sv */
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tcgc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* rtl/core/three_circle_grid_collision_check_core.sv */
// three-circle collision check on a one-bit occupancy grid, top level
// depends on tcgc_pkg and tcgc_ram
`timescale 1ns / 1ps

// usage
// - input stream: tuser is the mode (0 writes one grid cell, 1 queries a pose);
//   tdata carries cell column/row/byte, pose x/y (signed q12.8) and heading
// - a write transfer stores occupied = (byte == 100) and gives no output
// - a query gives one output transfer: collision_free and a three-bit mask of
//   circle centres that fell outside the map (centre, front, rear)
// - map size and circle offset come from the plain write port; change them only
//   while no query is in flight
// - write: the next transfer may follow in the next cycle
// - query: the step sequencer runs one query at a time through probe centre,
//   eval centre, probe front, eval front (which also probes the rear), eval rear
//   and done; a hit in an eval jumps straight to done, and the result becomes
//   valid as the sequencer returns to idle, ready for the next transfer; every
//   probe is one read of the single-port grid ram, compared in the next step
// - input ready is high whenever the sequencer is idle, also while a result
//   still waits in the output register
// - when the receiver stalls, a finished query holds in its last step until the
//   output register frees up, so results are never dropped or overwritten
// - reset (synchronous, active low) clears the sequencer and output valid and
//   loads the register defaults 256, 256, 1; grid contents are not cleared

module three_circle_grid_collision_check_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [tcgc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tcgc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // cell_column, cell_row, cell_byte, pose_x, pose_y, heading, zero pad
    input  logic [tcgc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // mode
    input  logic [tcgc_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // collision_free, outside_mask, zero pad
    output logic [tcgc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    import tcgc_pkg::*;

    typedef struct packed {
        logic              neg;     // truncated index below zero
        logic [CELL_W-1:0] idx;
    } t_cell;

    // q14 coordinate to cell index, truncated toward zero
    function automatic t_cell to_cell(input logic signed [COORD_W-1:0] v);
        t_cell o;
        o.neg = 1'b0;
        o.idx = v[COORD_W-1:FRAC_BITS];
        if (v[COORD_W-1]) begin
            o.idx = '0;
            // values in (-1, 0) cells truncate to cell zero
            o.neg = !((&v[COORD_W-1:FRAC_BITS]) && (|v[FRAC_BITS-1:0]));
        end
        return o;
    endfunction

    // configuration registers
    logic [SIZE_W-1:0]   r_map_width;
    logic [SIZE_W-1:0]   r_map_height;
    logic [OFFSET_W-1:0] r_circle_offset;

    // sequencer and output control
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                r_out_valid;
    logic [OUT_FIELD_W-1:0] r_out_data;
    t_uword              uw;

    // query datapath
    logic signed [POS_W-1:0] r_x14;
    logic signed [POS_W-1:0] r_y14;
    logic [HEADING_BITS-1:0] r_heading;
    logic [2*TRIG_W-1:0]     r_trig;
    logic signed [DX_W-1:0]  r_dx;
    logic signed [DX_W-1:0]  r_dy;
    logic                    r_probe_out;
    logic [1:0]              r_probe_sel;
    logic [MASK_W-1:0]       r_mask;
    logic                    r_free;

    // input field views
    logic                           in_mode;
    logic [CELL_FIELD_W-1:0]        in_col;
    logic [CELL_FIELD_W-1:0]        in_row;
    logic [CELL_FIELD_W-1:0]        in_byte;
    logic signed [POSE_W-1:0]       in_px;
    logic signed [POSE_W-1:0]       in_py;
    logic [HEADING_W-1:0]           in_heading;
    logic                           in_xfer;
    logic                           out_slot_free;

    // combinational datapath
    logic signed [TRIG_S_W-1:0] cs;
    logic signed [TRIG_S_W-1:0] sn;
    logic signed [DX_W-1:0]     off_s;
    logic signed [COORD_W-1:0]  vx;
    logic signed [COORD_W-1:0]  vy;
    t_cell                      cx;
    t_cell                      cy;
    logic [CELL_W-1:0]          w_eff;
    logic [CELL_W-1:0]          h_eff;
    logic                       probe_out;
    logic [MAP_ADDR_BITS-1:0]   probe_addr;
    logic                       hit;

    // grid ram port
    logic                     ram_we;
    logic [MAP_ADDR_BITS-1:0] ram_addr;
    logic [0:0]               ram_wdata;
    logic [0:0]               ram_rdata;

    assign in_mode    = s_axis_tuser[0];
    assign in_col     = s_axis_tdata[COL_LSB +: CELL_FIELD_W];
    assign in_row     = s_axis_tdata[ROW_LSB +: CELL_FIELD_W];
    assign in_byte    = s_axis_tdata[BYTE_LSB +: CELL_FIELD_W];
    assign in_px      = s_axis_tdata[PX_LSB +: POSE_W];
    assign in_py      = s_axis_tdata[PY_LSB +: POSE_W];
    assign in_heading = s_axis_tdata[HEAD_LSB +: HEADING_W];

    assign s_axis_tready = (r_step == STEP_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_slot_free = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    // current control word
    assign uw = ucode(r_step);

    // quadrant fold of the quarter-wave entry
    always_comb begin
        case (r_heading[HEADING_BITS-1 -: 2])
            2'd0: begin
                cs = TRIG_S_W'(r_trig[TRIG_W-1:0]);
                sn = TRIG_S_W'(r_trig[2*TRIG_W-1:TRIG_W]);
            end
            2'd1: begin
                cs = -TRIG_S_W'(r_trig[2*TRIG_W-1:TRIG_W]);
                sn = TRIG_S_W'(r_trig[TRIG_W-1:0]);
            end
            2'd2: begin
                cs = -TRIG_S_W'(r_trig[TRIG_W-1:0]);
                sn = -TRIG_S_W'(r_trig[2*TRIG_W-1:TRIG_W]);
            end
            default: begin
                cs = TRIG_S_W'(r_trig[2*TRIG_W-1:TRIG_W]);
                sn = -TRIG_S_W'(r_trig[TRIG_W-1:0]);
            end
        endcase
    end

    assign off_s = DX_W'(signed'({1'b0, r_circle_offset}));

    // effective map size, saturated to the grid maximum
    assign w_eff = (r_map_width > SIZE_W'(MAX_MAP_WIDTH)) ? CELL_W'(MAX_MAP_WIDTH)
                                                          : CELL_W'(r_map_width);
    assign h_eff = (r_map_height > SIZE_W'(MAX_MAP_HEIGHT)) ? CELL_W'(MAX_MAP_HEIGHT)
                                                            : CELL_W'(r_map_height);

    // probe coordinate for the selected circle
    always_comb begin
        case (uw.probe_sel)
            SEL_FRONT: begin
                vx = COORD_W'(r_x14) + COORD_W'(r_dx);
                vy = COORD_W'(r_y14) + COORD_W'(r_dy);
            end
            SEL_REAR: begin
                vx = COORD_W'(r_x14) - COORD_W'(r_dx);
                vy = COORD_W'(r_y14) - COORD_W'(r_dy);
            end
            default: begin
                vx = COORD_W'(r_x14);
                vy = COORD_W'(r_y14);
            end
        endcase
    end

    assign cx = to_cell(vx);
    assign cy = to_cell(vy);
    assign probe_out = cx.neg || cy.neg || (cx.idx >= w_eff) || (cy.idx >= h_eff);
    assign probe_addr = MAP_ADDR_BITS'(MAP_ADDR_BITS'(cy.idx) * MAP_ADDR_BITS'(MAX_MAP_WIDTH)
                                       + MAP_ADDR_BITS'(cx.idx));

    // grid port: writes only in idle, probes only while busy
    assign ram_we    = in_xfer && (in_mode == MODE_WRITE)
                       && (32'(in_col) < MAX_MAP_WIDTH) && (32'(in_row) < MAX_MAP_HEIGHT);
    assign ram_wdata = (in_byte == OCCUPIED_BYTE);
    assign ram_addr  = (r_step == STEP_IDLE)
        ? MAP_ADDR_BITS'(MAP_ADDR_BITS'(in_row) * MAP_ADDR_BITS'(MAX_MAP_WIDTH)
                         + MAP_ADDR_BITS'(in_col))
        : probe_addr;

    // occupied in-map cell from the previous probe
    assign hit = uw.eval_en && !r_probe_out && ram_rdata[0];

    // step counter with the hit jump and the output hold
    always_comb begin
        n_step = uw.next;
        if (r_step == STEP_IDLE) begin
            n_step = (in_xfer && (in_mode == MODE_QUERY)) ? STEP_PROBE_C : STEP_IDLE;
        end else if (uw.done) begin
            n_step = out_slot_free ? uw.next : r_step;
        end else if (hit) begin
            n_step = STEP_DONE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step          <= STEP_IDLE;
            r_out_valid     <= 1'b0;
            r_map_width     <= MAP_WIDTH_RST;
            r_map_height    <= MAP_HEIGHT_RST;
            r_circle_offset <= CIRCLE_OFFSET_RST;
        end else begin
            r_step <= n_step;
            if (uw.done && out_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAP_WIDTH:     r_map_width     <= i_cfg_data[SIZE_W-1:0];
                    CFG_MAP_HEIGHT:    r_map_height    <= i_cfg_data[SIZE_W-1:0];
                    CFG_CIRCLE_OFFSET: r_circle_offset <= i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // query payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && (in_mode == MODE_QUERY)) begin
            r_x14     <= {in_px, 6'b0};
            r_y14     <= {in_py, 6'b0};
            r_heading <= HEADING_BITS'(in_heading);
            r_mask    <= '0;
            r_free    <= 1'b1;
        end
        if (uw.trig_load) begin
            r_trig <= TRIG_ROM[r_heading[QUARTER_BITS-1:0]];
        end
        if (uw.mult_en) begin
            r_dx <= off_s * DX_W'(cs);
            r_dy <= off_s * DX_W'(sn);
        end
        if (uw.probe_en) begin
            r_probe_out <= probe_out;
            r_probe_sel <= uw.probe_sel;
        end
        if (hit) begin
            r_free <= 1'b0;
        end else if (uw.eval_en && r_probe_out) begin
            r_mask[r_probe_sel] <= 1'b1;
        end
        if (uw.done && out_slot_free) begin
            r_out_data <= {r_mask, r_free};
        end
    end

    // one bit per grid cell
    tcgc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

/* rtl/core/tcgc_checker.sv */
// port-level checker for the collision check core, bound to the top level
// depends on tcgc_pkg and the assertion macro header
`timescale 1ns / 1ps

`include "three_circle_grid_collision_check_core_assert.svh"

module tcgc_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic [tcgc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input logic [tcgc_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [tcgc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    import tcgc_pkg::*;

    logic in_query;
    logic in_write;

    assign in_query = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == MODE_QUERY)
                      && (s_axis_tdata[0] == s_axis_tdata[0]);
    assign in_write = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == MODE_WRITE);

    // output is empty right after reset
    `TCGC_ASSERT_NEXT_NORST(a_out_empty_after_reset, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

    // a stalled result stays put
    `TCGC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // a query keeps the block busy for at least the next cycle
    `TCGC_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_query, !s_axis_tready, "ready right after a query transfer")

    // a cell write never produces a result
    `TCGC_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, in_write && !m_axis_tvalid, !m_axis_tvalid, "result after a cell write")

endmodule

bind three_circle_grid_collision_check_core tcgc_checker u_tcgc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb.sv */
// self-checking testbench for the three-circle grid collision check core
// depends on tcgc_pkg and the core RTL; predicts every query result in-house
`timescale 1ns / 1ps

module tb;
    import tcgc_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int DRAIN_CYCLES     = 16;      // well past the longest query latency
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // one input transfer, unpacked
    typedef struct {
        logic               mode;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [7:0]         cbyte;
        logic signed [20:0] px;
        logic signed [20:0] py;
        logic [11:0]        hd;
    } t_grid_item;

    // one output transfer
    typedef struct packed {
        logic       free;
        logic [2:0] mask;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // cell_column, cell_row, cell_byte, pose_x, pose_y, heading
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // collision_free, outside_mask

    // shadow of the block: registers and the grid, plus which cells were written
    logic [8:0] map_width_q;
    logic [8:0] map_height_q;
    logic [7:0] offset_q;
    bit         occ_map [MAP_DEPTH];
    bit         cell_written [MAP_DEPTH];

    t_verdict predicted_verdicts[$];
    t_verdict oldest_verdict;
    int       error_count = 0;
    int       items_sent  = 0;
    int       cycle_count = 0;
    bit       idle_en     = 1'b1;
    bit       long_hold   = 1'b0;

    three_circle_grid_collision_check_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // clamp a q2.30 taylor sum to [0, 1] and round to q1.14
    function automatic int q30_round_q14(input longint v);
        longint cl;
        cl = v;
        if (cl < 0) cl = 0;
        if (cl > (longint'(1) << 30)) cl = longint'(1) << 30;
        return int'((cl + 32768) >>> 16);
    endfunction

    // cos and sin of a heading index in q1.14, from first-quadrant taylor sums
    function automatic void heading_trig(input logic [11:0] hd, output int cs, output int sn);
        longint unsigned p;
        longint unsigned ang;
        longint unsigned term;
        longint          s_acc;
        longint          c_acc;
        int              s14;
        int              c14;
        logic [1:0]      quad;
        p    = (64'(hd) << 32) / 64'(HEADING_STEPS);
        quad = p[31:30];
        ang  = ((p & 64'h3FFF_FFFF) * HALF_PI_Q30) >> 30;
        s_acc = 0;
        term  = ang;
        for (int i = 0; i < 8; i++) begin
            s_acc = (i % 2 == 1) ? s_acc - longint'(term) : s_acc + longint'(term);
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / 64'((2 * i + 2) * (2 * i + 3));
        end
        c_acc = 0;
        term  = 64'd1 << 30;
        for (int i = 0; i < 9; i++) begin
            c_acc = (i % 2 == 1) ? c_acc - longint'(term) : c_acc + longint'(term);
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / 64'((2 * i + 1) * (2 * i + 2));
        end
        s14 = q30_round_q14(s_acc);
        c14 = q30_round_q14(c_acc);
        // fold the quarter-wave result into the right quadrant
        case (quad)
            2'd0: begin cs = c14;  sn = s14;  end
            2'd1: begin cs = -s14; sn = c14;  end
            2'd2: begin cs = -c14; sn = -s14; end
            default: begin cs = s14; sn = -c14; end
        endcase
    endfunction

    // grid addresses of centre, front and rear, and which of them leave the map
    function automatic void locate_centres(input t_grid_item it, output logic [2:0] outside,
                                           output logic [2:0][15:0] addr);
        int     cs;
        int     sn;
        longint px64;
        longint py64;
        longint ddx;
        longint ddy;
        longint sgn;
        longint cx;
        longint cy;
        longint eff_w;
        longint eff_h;
        heading_trig(it.hd, cs, sn);
        px64 = longint'(it.px) * 64;
        py64 = longint'(it.py) * 64;
        ddx  = longint'(offset_q) * cs;
        ddy  = longint'(offset_q) * sn;
        // sizes above the grid saturate
        eff_w = map_width_q;
        eff_h = map_height_q;
        if (eff_w > MAX_MAP_WIDTH) eff_w = MAX_MAP_WIDTH;
        if (eff_h > MAX_MAP_HEIGHT) eff_h = MAX_MAP_HEIGHT;
        for (int k = 0; k < 3; k++) begin
            sgn = (k == 0) ? 0 : (k == 1) ? 1 : -1;
            // q.14 to whole cells, truncating toward zero
            cx = (px64 + sgn * ddx) / 16384;
            cy = (py64 + sgn * ddy) / 16384;
            outside[k] = (cx < 0) || (cx >= eff_w) || (cy < 0) || (cy >= eff_h);
            addr[k]    = outside[k] ? 16'd0 : 16'(cy * MAX_MAP_WIDTH + cx);
        end
    endfunction

    // expected output of a query; stops at the first occupied in-map centre
    function automatic t_verdict predict_verdict(input t_grid_item it);
        t_verdict         v;
        logic [2:0]       outside;
        logic [2:0][15:0] addr;
        bit               hit;
        locate_centres(it, outside, addr);
        v.free = 1'b1;
        v.mask = 3'b000;
        hit    = 1'b0;
        for (int k = 0; k < 3 && !hit; k++) begin
            v.mask[k] = outside[k];
            if (!outside[k] && occ_map[addr[k]]) begin
                hit    = 1'b1;
                v.free = 1'b0;
            end
        end
        return v;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic set_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (index)
            CFG_MAP_WIDTH:     map_width_q  = value;
            CFG_MAP_HEIGHT:    map_height_q = value;
            CFG_CIRCLE_OFFSET: offset_q     = value[7:0];
            default: ;   // unused index leaves everything alone
        endcase
    endtask

    // offer one transfer, with an optional idle burst first, and record its effect
    task automatic send_item(input t_grid_item it);
        int gap;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser = it.mode;
        s_axis_tdata = '0;
        s_axis_tdata[COL_LSB +: CELL_FIELD_W]  = it.col;
        s_axis_tdata[ROW_LSB +: CELL_FIELD_W]  = it.row;
        s_axis_tdata[BYTE_LSB +: CELL_FIELD_W] = it.cbyte;
        s_axis_tdata[PX_LSB +: POSE_W]         = it.px;
        s_axis_tdata[PY_LSB +: POSE_W]         = it.py;
        s_axis_tdata[HEAD_LSB +: HEADING_W]    = it.hd;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (it.mode == MODE_WRITE) begin
            occ_map[{it.row, it.col}]      = (it.cbyte == OCCUPIED_BYTE);
            cell_written[{it.row, it.col}] = 1'b1;
        end else begin
            predicted_verdicts.push_back(predict_verdict(it));
        end
    endtask

    // occupied often enough that every centre sees hits
    function automatic logic [7:0] random_byte();
        return ($urandom_range(0, 2) == 0) ? OCCUPIED_BYTE : 8'($urandom);
    endfunction

    task automatic write_cell(input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] cbyte);
        t_grid_item it;
        it.mode  = MODE_WRITE;
        it.col   = col;
        it.row   = row;
        it.cbyte = cbyte;
        // pose fields carry noise on a write
        it.px = 21'($urandom);
        it.py = 21'($urandom);
        it.hd = 12'($urandom);
        send_item(it);
    endtask

    // query a pose; any in-map centre on a never-written cell gets written first
    task automatic query_pose(input logic signed [20:0] px, input logic signed [20:0] py,
                              input logic [11:0] hd);
        t_grid_item       it;
        logic [2:0]       outside;
        logic [2:0][15:0] addr;
        it.mode  = MODE_QUERY;
        it.col   = 8'($urandom);
        it.row   = 8'($urandom);
        it.cbyte = 8'($urandom);
        it.px    = px;
        it.py    = py;
        it.hd    = hd;
        locate_centres(it, outside, addr);
        for (int k = 0; k < 3; k++) begin
            if (!outside[k] && !cell_written[addr[k]])
                write_cell(addr[k][7:0], addr[k][15:8], random_byte());
        end
        send_item(it);
    endtask

    // stop offering, let every result arrive, then a quiet drain stretch
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (predicted_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // coordinate in q12.8 mostly near the map, sometimes anywhere
    function automatic logic signed [20:0] random_coord(input int span);
        int whole;
        if ($urandom_range(0, 9) == 0) return 21'($urandom);
        whole = $urandom_range(0, span + 3) - 2;
        return 21'(whole * 256 + $urandom_range(0, 255));
    endfunction

    task automatic run_random_phase(input int n_items, input bit allow_idle);
        int start;
        int iter;
        int span_x;
        int span_y;
        start  = items_sent;
        iter   = 0;
        span_x = (map_width_q > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : map_width_q;
        span_y = (map_height_q > MAX_MAP_HEIGHT) ? MAX_MAP_HEIGHT : map_height_q;
        while (items_sent - start < n_items) begin
            // alternate stretches with and without idle bursts
            if (iter % 80 == 0) idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            iter++;
            if ($urandom_range(0, 4) == 0) begin
                if (span_x == 0 || span_y == 0 || $urandom_range(0, 9) == 0)
                    write_cell(8'($urandom), 8'($urandom), random_byte());
                else
                    write_cell(8'($urandom_range(0, span_x - 1)),
                               8'($urandom_range(0, span_y - 1)), random_byte());
            end else begin
                query_pose(random_coord(span_x), random_coord(span_y),
                           12'($urandom_range(0, HEADING_STEPS - 1)));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // corner cells, field extremes, the four axis headings, early stop, rear outside
    task automatic test_directed_cases();
        write_cell(8'd255, 8'd255, OCCUPIED_BYTE);
        write_cell(8'd0, 8'd0, OCCUPIED_BYTE);
        write_cell(8'd0, 8'd255, 8'd0);
        write_cell(8'd255, 8'd0, 8'd255);
        write_cell(8'd1, 8'd0, 8'd99);
        write_cell(8'd0, 8'd1, 8'd101);
        // centre on an occupied cell stops the check at once
        query_pose(21'sd128, 21'sd128, 12'd0);
        // pose at the field extremes, everything off the map, then the occupied far corner
        query_pose(21'sd1048575, -21'sd1048576, 12'd1024);
        query_pose(-21'sd1048576, 21'sd1048575, 12'd3072);
        query_pose(21'sd65510, 21'sd65510, 12'd0);
        // free centre, front lands on the occupied origin
        query_pose(21'sd384, 21'sd128, 12'd2048);
        // rear circle steps past the last column
        query_pose(21'sd65408, 21'sd2688, 12'd2048);
        // small negative x truncates to column zero; rear hits the origin
        query_pose(-21'sd128, 21'sd384, 12'd1024);
        query_pose(21'sd384, 21'sd384, 12'd4095);
        query_pose(21'sd640, 21'sd640, 12'd512);
        wait_idle();
    endtask

    // a zero width or height puts every centre outside
    task automatic test_zero_size();
        set_register(CFG_MAP_WIDTH, 9'd0);
        query_pose(21'sd128, 21'sd128, 12'd0);
        query_pose(21'sd2000, 21'sd700, 12'd300);
        wait_idle();
        set_register(CFG_MAP_WIDTH, 9'd256);
        set_register(CFG_MAP_HEIGHT, 9'd0);
        query_pose(21'sd128, 21'sd128, 12'd2048);
        query_pose(21'sd5000, 21'sd10, 12'd3500);
        wait_idle();
        set_register(CFG_MAP_HEIGHT, 9'd256);
    endtask

    // receiver holds off for a long stretch while queries keep coming
    task automatic test_output_stall();
        set_register(CFG_MAP_WIDTH, 9'd8);
        set_register(CFG_MAP_HEIGHT, 9'd8);
        set_register(CFG_CIRCLE_OFFSET, 9'd2);
        idle_en   = 1'b0;
        long_hold = 1'b1;
        repeat (20) query_pose(random_coord(8), random_coord(8), 12'($urandom));
        wait_idle();
    endtask

    task automatic test_defaults_random();
        set_register(CFG_MAP_WIDTH, 9'd256);
        set_register(CFG_MAP_HEIGHT, 9'd256);
        set_register(CFG_CIRCLE_OFFSET, 9'd1);
        run_random_phase(300, 1'b1);
        wait_idle();
    endtask

    task automatic test_small_map();
        set_register(CFG_MAP_WIDTH, 9'd16);
        set_register(CFG_MAP_HEIGHT, 9'd12);
        set_register(CFG_CIRCLE_OFFSET, 9'd3);
        run_random_phase(250, 1'b1);
        wait_idle();
    endtask

    // smallest map and zero offset: all three centres coincide
    task automatic test_single_cell_map();
        set_register(CFG_MAP_WIDTH, 9'd1);
        set_register(CFG_MAP_HEIGHT, 9'd1);
        set_register(CFG_CIRCLE_OFFSET, 9'd0);
        run_random_phase(120, 1'b1);
        wait_idle();
    endtask

    // full map, largest offset; bit 8 of the data is dropped by the offset register
    task automatic test_full_map_long_offset();
        set_register(CFG_MAP_WIDTH, 9'd256);
        set_register(CFG_MAP_HEIGHT, 9'd256);
        set_register(CFG_CIRCLE_OFFSET, 9'h1FF);
        run_random_phase(250, 1'b1);
        wait_idle();
    endtask

    // sizes above the grid saturate; the unused index changes nothing
    task automatic test_oversize_and_unused_index();
        set_register(CFG_MAP_WIDTH, 9'd511);
        set_register(CFG_MAP_HEIGHT, 9'd257);
        set_register(CFG_CIRCLE_OFFSET, 9'd7);
        set_register(CFG_UNUSED_INDEX, 9'($urandom));
        set_register(CFG_UNUSED_INDEX, 9'h1FF);
        run_random_phase(250, 1'b1);
        wait_idle();
    endtask

    // last stretch at full rate on both sides
    task automatic test_no_idle_final();
        set_register(CFG_MAP_WIDTH, 9'd40);
        set_register(CFG_MAP_HEIGHT, 9'd200);
        set_register(CFG_CIRCLE_OFFSET, 9'd2);
        run_random_phase(300, 1'b0);
        idle_en = 1'b0;
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold on request
    // ---------------------------------------------------------------
    always begin
        @(negedge i_clk);
        if (long_hold) begin
            m_axis_tready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            long_hold = 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // result checker: every output transfer against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_verdicts.size() == 0) begin
                $error("result transfer with none expected, tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                oldest_verdict = predicted_verdicts.pop_front();
                if (m_axis_tdata[0] !== oldest_verdict.free) begin
                    $error("collision_free mismatch: expected %0d, actual %0d",
                           oldest_verdict.free, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[3:1] !== oldest_verdict.mask) begin
                    $error("outside_mask mismatch: expected %0d, actual %0d",
                           oldest_verdict.mask, m_axis_tdata[3:1]);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        // register defaults after reset; grid shadow starts with nothing written
        map_width_q  = MAP_WIDTH_RST;
        map_height_q = MAP_HEIGHT_RST;
        offset_q     = CIRCLE_OFFSET_RST;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_zero_size();
        test_output_stall();
        test_defaults_random();
        test_small_map();
        test_single_cell_map();
        test_full_map_long_offset();
        test_oversize_and_unused_index();
        test_no_idle_final();

        if (error_count == 0 && predicted_verdicts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tcgc_pkg.sv
rtl/core/tcgc_ram.sv
rtl/core/three_circle_grid_collision_check_core.sv
rtl/core/tcgc_checker.sv
verif/tb.sv
